### rtl/pcsf_pkg.sv
// ----------------------------------------------------------------------------
// pcsf_pkg
// Shared types, codes and byte tables of the plotter command stream filter.
// ----------------------------------------------------------------------------
package pcsf_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] FUNC_CHAR  = 2'd0;
  localparam logic [1:0] FUNC_EOF   = 2'd1;
  localparam logic [1:0] FUNC_SOF   = 2'd2;
  localparam logic [1:0] FUNC_FINAL = 2'd3;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ONE  = 8'h31;

  // Escape sequence placed ahead of the command bytes
  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_RESET,
    PRE_SETUP
  } pre_kind_t;

  // Fixed string placed after the command bytes
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_NL,
    TAIL_SP,
    TAIL_EOF
  } tail_kind_t;

  // One event's output run, in compact form
  typedef struct packed {
    pre_kind_t  pre;
    logic       b0_v;
    logic [7:0] b0;
    logic       b1_v;
    logic [7:0] b1;
    tail_kind_t tail;
  } job_t;

  // Setup sequence; the reset sequence is its first seven bytes
  function automatic logic [7:0] setup_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = CH_ESC;
      4'd1:    b = 8'h45;  // E
      4'd2:    b = CH_ESC;
      4'd3:    b = 8'h28;  // (
      4'd4:    b = 8'h31;  // 1
      4'd5:    b = 8'h30;  // 0
      4'd6:    b = 8'h55;  // U
      4'd7:    b = CH_ESC;
      4'd8:    b = 8'h26;  // &
      4'd9:    b = 8'h6C;  // l
      4'd10:   b = 8'h31;  // 1
      4'd11:   b = 8'h4F;  // O
      4'd12:   b = CH_ESC;
      4'd13:   b = 8'h25;  // %
      4'd14:   b = 8'h30;  // 0
      default: b = 8'h42;  // B
    endcase
    return b;
  endfunction

  function automatic logic [3:0] pre_last_idx(input pre_kind_t pre);
    logic [3:0] n;
    case (pre)
      PRE_RESET: n = 4'd6;
      default:   n = 4'd15;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] tail_last_idx(input tail_kind_t tail);
    logic [1:0] n;
    case (tail)
      TAIL_SP:  n = 2'd2;
      TAIL_EOF: n = 2'd2;
      default:  n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] tail_byte(input tail_kind_t tail, input logic [1:0] idx);
    logic [7:0] b;
    case (tail)
      TAIL_SP: begin
        case (idx)
          2'd0:    b = CH_ONE;
          2'd1:    b = CH_SEMI;
          default: b = CH_NL;
        endcase
      end
      TAIL_EOF: begin
        case (idx)
          2'd1:    b = CH_NL;
          default: b = CH_SEMI;
        endcase
      end
      default: b = CH_NL;
    endcase
    return b;
  endfunction

endpackage

### rtl/plotter_command_stream_filter_unit.sv
// ----------------------------------------------------------------------------
// plotter_command_stream_filter_unit
// Rewrites a two-letter plotter command stream into a printer byte stream.
// ----------------------------------------------------------------------------
// Input side is a queue write port: an event (func, in_byte) transfers on a
// clock edge with push high and full low. Output side is a queue read port:
// while empty is low, out_byte/last_of_run show the oldest byte, and it
// transfers on an edge with pop high. last_of_run marks the final byte that
// one event produces; events that produce nothing leave no trace.
// The parser takes one event per cycle and writes a compact job record into
// a JOB_DEPTH-entry job queue; the sequencer expands one job at a time at
// one output byte per cycle (an event yields 0 to 18 bytes). With an idle
// sequencer a job passes the queue and job register ahead of the output
// register. Input throughput is one event per cycle until the job queue fills,
// so sustained rate is set by the byte count per event at the sequencer.
// A stalled reader holds the output register; the sequencer then stops and
// the job queue raises full once it holds JOB_DEPTH jobs.
// Reset (rst, synchronous) empties both queues, sets first-letter mode,
// clears the first letter, sets the setup flag and the terminator to 3.
// cfg_write loads cfg_data into the label terminator; write it while idle.
// ----------------------------------------------------------------------------
module plotter_command_stream_filter_unit import pcsf_pkg::*; #(
  parameter int JOB_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data
);

  logic take;
  job_t job;
  logic job_push;
  job_t head;
  logic head_avail;
  logic head_take;

  assign take = push && !full;

  pcsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .func      (func),
    .in_byte   (in_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .job       (job),
    .job_push  (job_push)
  );

  pcsf_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job),
    .full   (full),
    .rd_en  (head_take),
    .rd_job (head),
    .avail  (head_avail)
  );

  pcsf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_avail  (head_avail),
    .head_take   (head_take),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

### rtl/pcsf_front.sv
// ----------------------------------------------------------------------------
// pcsf_front
// Parser: tracks the command state and turns each event into a job record.
// ----------------------------------------------------------------------------
module pcsf_front import pcsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [1:0] func,
  input  logic [7:0] in_byte,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output job_t       job,
  output logic       job_push
);

  typedef enum logic [2:0] {
    MODE_FIRST  = 3'd0,
    MODE_SECOND = 3'd1,
    MODE_LABEL  = 3'd2,
    MODE_COPY   = 3'd3,
    MODE_SKIP   = 3'd4
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] first_letter;
  logic [7:0] first_letter_next;
  logic       setup_pending;
  logic       setup_pending_next;
  logic [7:0] label_terminator;

  logic       letter;
  logic [7:0] low_c;

  always_comb begin
    letter = ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ||
             ((in_byte >= 8'h61) && (in_byte <= 8'h7A));
    low_c  = ((in_byte >= 8'h41) && (in_byte <= 8'h5A)) ? (in_byte | 8'h20) : in_byte;
  end

  always_comb begin
    mode_next          = mode;
    first_letter_next  = first_letter;
    setup_pending_next = setup_pending;
    job.pre  = PRE_NONE;
    job.b0_v = 1'b0;
    job.b0   = in_byte;
    job.b1_v = 1'b0;
    job.b1   = low_c;
    job.tail = TAIL_NONE;

    case (func)
      FUNC_CHAR: begin
        case (mode)
          MODE_SECOND: begin
            job.b0 = first_letter;
            if (first_letter == 8'h69 && low_c == 8'h6E) begin        // in
              if (setup_pending) begin
                job.pre = PRE_SETUP;
              end
              setup_pending_next = 1'b1;
              job.b0_v  = 1'b1;
              job.b1_v  = 1'b1;
              mode_next = MODE_COPY;
            end else if (first_letter == 8'h6C && low_c == 8'h62) begin // lb
              job.b0_v  = 1'b1;
              job.b1_v  = 1'b1;
              mode_next = MODE_LABEL;
            end else if (first_letter == 8'h73 && low_c == 8'h70) begin // sp
              job.b0_v  = 1'b1;
              job.b1_v  = 1'b1;
              job.tail  = TAIL_SP;
              mode_next = MODE_SKIP;
            end else if (first_letter == 8'h76 && low_c == 8'h73) begin // vs
              mode_next = MODE_SKIP;
            end else begin
              job.b0_v  = 1'b1;
              job.b1_v  = 1'b1;
              mode_next = MODE_COPY;
            end
          end
          MODE_LABEL: begin
            job.b0_v = 1'b1;
            if (in_byte == label_terminator) begin
              job.tail  = TAIL_NL;
              mode_next = MODE_FIRST;
            end
          end
          MODE_COPY: begin
            if (letter) begin
              first_letter_next = low_c;
              mode_next         = MODE_SECOND;
            end else begin
              job.b0_v = 1'b1;
              if (in_byte == CH_SEMI) begin
                mode_next = MODE_FIRST;
              end
            end
          end
          MODE_SKIP: begin
            if (letter) begin
              first_letter_next = low_c;
              mode_next         = MODE_SECOND;
            end else if (in_byte == CH_SEMI) begin
              mode_next = MODE_FIRST;
            end
          end
          default: begin
            if (letter) begin
              first_letter_next = low_c;
              mode_next         = MODE_SECOND;
            end else begin
              job.b0_v = 1'b1;
            end
          end
        endcase
      end
      FUNC_EOF: begin
        // label text still open: close it with the terminator first
        job.b0   = label_terminator;
        job.b0_v = (mode == MODE_LABEL);
        job.tail = TAIL_EOF;
      end
      FUNC_SOF: begin
        job.pre            = PRE_SETUP;
        setup_pending_next = 1'b0;
      end
      default: begin
        job.pre = PRE_RESET;
      end
    endcase
  end

  // drop events that emit nothing
  assign job_push = take && ((job.pre != PRE_NONE) || job.b0_v || (job.tail != TAIL_NONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_FIRST;
      first_letter     <= 8'h00;
      setup_pending    <= 1'b1;
      label_terminator <= 8'h03;
    end else begin
      if (take) begin
        mode          <= mode_next;
        first_letter  <= first_letter_next;
        setup_pending <= setup_pending_next;
      end
      if (cfg_write) begin
        label_terminator <= cfg_data;
      end
    end
  end

endmodule

### rtl/pcsf_job_queue.sv
// ----------------------------------------------------------------------------
// pcsf_job_queue
// Small FIFO of job records between parser and byte sequencer.
// ----------------------------------------------------------------------------
module pcsf_job_queue import pcsf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic avail
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_FULL);
  assign avail  = (count != '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/pcsf_back.sv
// ----------------------------------------------------------------------------
// pcsf_back
// Byte sequencer: walks each job record and issues one byte per cycle
// into the output register whenever that register is empty or popped.
// ----------------------------------------------------------------------------
module pcsf_back import pcsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       head_avail,
  output logic       head_take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_of_run
);

  typedef enum logic [1:0] {
    SEG_PRE,
    SEG_B0,
    SEG_B1,
    SEG_TAIL
  } seg_t;

  logic       busy;
  job_t       cur;
  seg_t       seg;
  logic [3:0] idx;
  logic       out_valid;

  seg_t       seg_next;
  logic [3:0] idx_next;
  logic       done;
  logic [7:0] cur_byte;
  seg_t       start_seg;
  logic       adv;

  assign adv   = !out_valid || pop;
  assign empty = !out_valid;

  always_comb begin
    case (seg)
      SEG_PRE:  cur_byte = setup_byte(idx);
      SEG_B0:   cur_byte = cur.b0;
      SEG_B1:   cur_byte = cur.b1;
      default:  cur_byte = tail_byte(cur.tail, idx[1:0]);
    endcase
  end

  always_comb begin
    seg_next = SEG_TAIL;
    idx_next = '0;
    done     = 1'b0;
    case (seg)
      SEG_PRE: begin
        if (idx != pre_last_idx(cur.pre)) begin
          seg_next = SEG_PRE;
          idx_next = idx + 4'd1;
        end else if (cur.b0_v) begin
          seg_next = SEG_B0;
        end else if (cur.tail == TAIL_NONE) begin
          done = 1'b1;
        end
      end
      SEG_B0: begin
        if (cur.b1_v) begin
          seg_next = SEG_B1;
        end else if (cur.tail == TAIL_NONE) begin
          done = 1'b1;
        end
      end
      SEG_B1: begin
        done = (cur.tail == TAIL_NONE);
      end
      default: begin
        if (idx[1:0] != tail_last_idx(cur.tail)) begin
          idx_next = idx + 4'd1;
        end else begin
          done = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    if (head.pre != PRE_NONE) begin
      start_seg = SEG_PRE;
    end else if (head.b0_v) begin
      start_seg = SEG_B0;
    end else begin
      start_seg = SEG_TAIL;
    end
  end

  // load on idle, or straight behind the final byte of the current run
  assign head_take = head_avail && (!busy || (adv && done));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (busy && adv) begin
        out_valid   <= 1'b1;
        out_byte    <= cur_byte;
        last_of_run <= done;
        if (!done) begin
          seg <= seg_next;
          idx <= idx_next;
        end else if (!head_avail) begin
          busy <= 1'b0;
        end
      end else begin
        out_valid <= out_valid && !pop;
      end
      if (head_take) begin
        busy <= 1'b1;
        cur  <= head;
        seg  <= start_seg;
        idx  <= '0;
      end
    end
  end

endmodule

### rtl/pcsf_checker.sv
// ----------------------------------------------------------------------------
// pcsf_checker
// Port-level checks of the command stream filter, bound to the top level.
// ----------------------------------------------------------------------------
module pcsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // reset drains the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // reset drains the job queue
  a_rst_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full asserted after reset");

  // queue fill only grows on an input transfer
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("full rose without an input transfer");

  // stalled output holds its byte
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_of_run)))
    else $error("output changed while stalled");

endmodule

bind plotter_command_stream_filter_unit pcsf_checker u_pcsf_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);
